/* sv/plst_pkg.sv */
`default_nettype none

package plst_pkg;

    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 2;

    // Request codes
    localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_END   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_AT    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd6;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [ST_W-1:0]          status;
        logic [POS_W-1:0]         entries_now;
        logic                     last;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic edit;
        logic rd_start;
        logic rd_step;
        logic rd_empty;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic rd_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* sv/plst_ctrl.sv */
`default_nettype none

module plst_ctrl import plst_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire t_stat            i_stat,
    output logic                  o_req_ready,
    output t_cmd                  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_req_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign w_accept    = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action != ACT_READ) begin
                        o_cmd.edit = 1'b1;
                    end else if (i_stat.empty) begin
                        o_cmd.rd_empty = 1'b1;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.rd_step = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* sv/plst_dp.sv */
`default_nettype none

module plst_dp import plst_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    input  wire logic i_rsp_ready,
    output t_stat     o_stat,
    output logic      o_rsp_valid,
    output t_rsp      o_rsp
);

    localparam int               CW      = $clog2(LIST_DEPTH + 1);
    localparam logic [POS_W-1:0] DEPTH_P = POS_W'(LIST_DEPTH);

    logic [WORD_W-1:0] r_cell [LIST_DEPTH];
    logic [WORD_W-1:0] n_cell [LIST_DEPTH];
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    logic [POS_W-1:0]  w_count;
    logic              w_ins, w_del;
    logic [POS_W-1:0]  w_idx;
    logic [ST_W-1:0]   w_status;
    logic [WORD_W-1:0] w_rm_word;

    assign w_count = POS_W'(r_count);

    // Decode the edit: where the gap opens or closes, and the status.
    always_comb begin
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_idx    = '0;
        w_status = ST_OK;
        case (i_req.action)
            ACT_APPEND, ACT_INS_FRONT, ACT_INS_AT: begin
                if (w_count == DEPTH_P) begin
                    w_status = ST_FULL;
                end else if (i_req.action == ACT_APPEND) begin
                    w_ins = 1'b1;
                    w_idx = w_count;
                end else if (i_req.action == ACT_INS_FRONT) begin
                    w_ins = 1'b1;
                end else if (i_req.position > w_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ins = 1'b1;
                    w_idx = i_req.position;
                end
            end
            ACT_DEL_FRONT, ACT_DEL_END, ACT_DEL_AT: begin
                if (w_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (i_req.action == ACT_DEL_FRONT) begin
                    w_del = 1'b1;
                end else if (i_req.action == ACT_DEL_END) begin
                    w_del = 1'b1;
                    w_idx = w_count - POS_W'(1);
                end else if (i_req.position >= w_count) begin
                    w_status = ST_RANGE;
                end else begin
                    w_del = 1'b1;
                    w_idx = i_req.position;
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    // One-hot select of the word being removed.
    always_comb begin
        w_rm_word = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (POS_W'(i) == w_idx) begin
                w_rm_word = w_rm_word | r_cell[i];
            end
        end
    end

    // Each cell holds, loads, or takes its left or right neighbour; a readout wraps cell 0 to the back.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.edit && w_ins) begin
                if (POS_W'(i) == w_idx) begin
                    n_cell[i] = i_req.value;
                end else if (POS_W'(i) > w_idx) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.edit && w_del) begin
                if (POS_W'(i) >= w_idx && i < LIST_DEPTH - 1) begin
                    n_cell[i] = r_cell[(i < LIST_DEPTH - 1) ? i + 1 : i];
                end
            end else if (i_cmd.rd_step) begin
                // Rotate the occupied entries so the front is always in cell 0.
                if (POS_W'(i + 1) < w_count) begin
                    n_cell[i] = r_cell[(i < LIST_DEPTH - 1) ? i + 1 : i];
                end else if (POS_W'(i + 1) == w_count) begin
                    n_cell[i] = r_cell[0];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.edit && w_ins) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.edit && w_del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.rd_start) begin
            n_rd_idx = '0;
        end else if (i_cmd.rd_step) begin
            n_rd_idx = r_rd_idx + CW'(1);
        end
    end

    always_comb begin
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        if (i_cmd.edit) begin
            n_rsp.word        = w_del ? w_rm_word : '0;
            n_rsp.status      = w_status;
            n_rsp.entries_now = POS_W'(n_count);
            n_rsp.last        = 1'b1;
            n_rsp_valid       = 1'b1;
        end else if (i_cmd.rd_empty) begin
            n_rsp.word        = '0;
            n_rsp.status      = ST_EMPTY;
            n_rsp.entries_now = '0;
            n_rsp.last        = 1'b1;
            n_rsp_valid       = 1'b1;
        end else if (i_cmd.rd_step) begin
            n_rsp.word        = r_cell[0];
            n_rsp.status      = ST_OK;
            n_rsp.entries_now = w_count;
            n_rsp.last        = o_stat.rd_last;
            n_rsp_valid       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_rd_idx <= n_rd_idx;
        r_rsp    <= n_rsp;
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.rd_last  = ((r_rd_idx + CW'(1)) == r_count);
    assign o_stat.out_free = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid     = r_rsp_valid;
    assign o_rsp           = r_rsp;

endmodule

`default_nettype wire

/* sv/positional_list_store_top.sv */
`default_nettype none
// An edit's result is registered and appears the cycle after it is accepted.
// Edits flow one per cycle while results are taken.
// A readout is accepted, then sends one entry a cycle from cell 0 while the output is free,
// each entry passing through the output register; an empty list's readout gives one result.
// Reset is synchronous and active low; it empties the list and drops any pending result,
// while the stored words themselves are left as they are.

module positional_list_store_top import plst_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    // The list lives in a row of shifting cells in the datapath, front in cell 0.
    // An insert opens a gap by moving every cell at or after the index one place
    // back, and a delete closes one by moving them forward. A readout rotates the
    // occupied cells once per cycle while the output is free, so the entry to send
    // is always in cell 0 and the list is back in order after the last one.

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller accepts a request only when idle and when the output register
    // is free or being emptied in the same cycle, so no result is ever overwritten.
    plst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_action    (i_req.action),
        .i_stat      (w_stat),
        .o_req_ready (o_req_ready),
        .o_cmd       (w_cmd)
    );

    plst_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .i_rsp_ready (i_rsp_ready),
        .o_stat      (w_stat),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // A request is only taken when its result has somewhere to go.
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> (!o_rsp_valid || i_rsp_ready))
        else $error("request taken while output register is blocked");

    // Every request other than a readout gives exactly one, final, result.
    a_edit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && i_req.action != ACT_READ)
        |=> (o_rsp_valid && o_rsp.last))
        else $error("edit request did not give a final result");

    // The reported count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.entries_now <= POS_W'(LIST_DEPTH)))
        else $error("entry count beyond store depth");

    // An empty status only ever reports an empty list.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_EMPTY) |-> (o_rsp.entries_now == '0))
        else $error("empty status with entries held");
`endif

endmodule

`default_nettype wire
